@@ rtl/ihp_pkg.sv @@
// ----------------------------------------------------------------------------
// ihp_pkg
// Shared types, constants and the hex digit decoder for the hex page packer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ihp_pkg;

  localparam int PAGE_BYTES_DEF = 256;

  typedef enum logic [1:0] {
    PH_COLON,
    PH_RECORD,
    PH_HALT
  } phase_t;

  localparam logic [1:0] ST_RUN   = 2'd0;
  localparam logic [1:0] ST_OK    = 2'd1;
  localparam logic [1:0] ST_UNSUP = 2'd2;
  localparam logic [1:0] ST_BAD   = 2'd3;

  localparam logic [7:0] CHAR_COLON   = 8'h3A;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

  localparam logic [7:0] REC_DATA = 8'h00;
  localparam logic [7:0] REC_EOF  = 8'h01;

  localparam logic [7:0] PAD_BYTE = 8'hFF;

  localparam logic [8:0] IDX_LENGTH = 9'd0;
  localparam logic [8:0] IDX_TYPE   = 9'd3;
  localparam logic [8:0] IDX_DATA   = 9'd4;
  localparam logic [8:0] IDX_MAX    = 9'd511;

  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } hex_digit_t;

  function automatic hex_digit_t hex_decode(input logic [7:0] c);
    hex_digit_t d;
    d.valid = 1'b0;
    d.value = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      d.valid = 1'b1;
      d.value = 4'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d.valid = 1'b1;
      d.value = 4'(c - 8'h37);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d.valid = 1'b1;
      d.value = 4'(c - 8'h57);
    end
    return d;
  endfunction

endpackage

`default_nettype wire

@@ rtl/intel_hex_page_packer.sv @@
// ----------------------------------------------------------------------------
// intel_hex_page_packer
// Parses Intel HEX text one character per item and packs data record bytes
// into fixed size pages, with padding and a status at the end of file.
//
// Usage:
//   char channel: restart and char_in with char_valid / char_stall. One
//   character is taken per cycle while char_stall is low; restart clears
//   parser and page fill before that character is handled.
//   result channel: byte_value, repeat_count, page_offset, page_end and
//   parse_status with result_valid / result_stall. A character gives zero or
//   one result item.
//   The result of a character is held in the single result register behind
//   the parser logic, shown from the cycle after the character is taken.
//   When the receiver stalls with a result waiting, char_stall goes high
//   until that result is taken; a character is still taken in the cycle in
//   which the waiting result leaves.
//   Reset puts the parser at line start with an empty page and no result.
//   After a finished, unsupported or malformed status, characters give no
//   result until a restart.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module intel_hex_page_packer #(
  parameter int PAGE_BYTES = ihp_pkg::PAGE_BYTES_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       char_valid,
  output logic            char_stall,
  input  wire logic       restart,
  input  wire logic [7:0] char_in,
  output logic            result_valid,
  input  wire logic       result_stall,
  output logic [7:0]      byte_value,
  output logic [8:0]      repeat_count,
  output logic [7:0]      page_offset,
  output logic            page_end,
  output logic [1:0]      parse_status
);

  localparam int FILL_W = $clog2(PAGE_BYTES + 1);

  ihp_pkg::phase_t   parse_phase, parse_phase_next;
  logic [3:0]        high_nibble, high_nibble_next;
  logic              nibble_pending, nibble_pending_next;
  logic [8:0]        record_byte_index, record_byte_index_next;
  logic [7:0]        record_length, record_length_next;
  logic [7:0]        record_type, record_type_next;
  logic [FILL_W-1:0] page_fill, page_fill_next;

  ihp_pkg::phase_t   b_phase;
  logic [3:0]        b_high;
  logic              b_pending;
  logic [8:0]        b_idx;
  logic [7:0]        b_len;
  logic [7:0]        b_type;
  logic [FILL_W-1:0] b_fill;

  ihp_pkg::hex_digit_t hex;
  logic              accept;
  logic              is_colon, is_newline;
  logic              take_byte;
  logic [7:0]        rec_byte;
  logic              at_length, at_type, data_hit;
  logic              rec_unsup, rec_eof;
  logic              fill_last;
  logic [FILL_W-1:0] pad_len;

  logic              emit;
  logic [7:0]        emit_byte;
  logic [8:0]        emit_repeat;
  logic [7:0]        emit_offset;
  logic              emit_end;
  logic [1:0]        emit_status;

  assign char_stall = result_valid & result_stall;
  assign accept     = char_valid & ~char_stall;

  // state as seen by this character, after an optional restart
  always_comb begin
    if (restart) begin
      b_phase   = ihp_pkg::PH_COLON;
      b_high    = 4'd0;
      b_pending = 1'b0;
      b_idx     = 9'd0;
      b_len     = 8'd0;
      b_type    = 8'd0;
      b_fill    = '0;
    end else begin
      b_phase   = parse_phase;
      b_high    = high_nibble;
      b_pending = nibble_pending;
      b_idx     = record_byte_index;
      b_len     = record_length;
      b_type    = record_type;
      b_fill    = page_fill;
    end
  end

  // character decode
  always_comb begin
    hex        = ihp_pkg::hex_decode(char_in);
    is_colon   = (char_in == ihp_pkg::CHAR_COLON);
    is_newline = (char_in == ihp_pkg::CHAR_NEWLINE);
    take_byte  = (b_phase == ihp_pkg::PH_RECORD) && !is_newline && hex.valid && b_pending;
    rec_byte   = {b_high, hex.value};
    at_length  = (b_idx == ihp_pkg::IDX_LENGTH);
    at_type    = (b_idx == ihp_pkg::IDX_TYPE);
    data_hit   = (b_idx >= ihp_pkg::IDX_DATA) &&
                 ((b_idx - ihp_pkg::IDX_DATA) < {1'b0, b_len}) &&
                 (b_type == ihp_pkg::REC_DATA);
    rec_unsup  = (b_len != 8'd0) && (rec_byte != ihp_pkg::REC_DATA);
    rec_eof    = (b_len == 8'd0) && (rec_byte == ihp_pkg::REC_EOF);
    fill_last  = (b_fill == FILL_W'(PAGE_BYTES - 1));
    pad_len    = FILL_W'(PAGE_BYTES) - b_fill;
  end

  // next state
  always_comb begin
    parse_phase_next       = parse_phase;
    high_nibble_next       = high_nibble;
    nibble_pending_next    = nibble_pending;
    record_byte_index_next = record_byte_index;
    record_length_next     = record_length;
    record_type_next       = record_type;
    page_fill_next         = page_fill;
    if (accept) begin
      parse_phase_next       = b_phase;
      high_nibble_next       = b_high;
      nibble_pending_next    = b_pending;
      record_byte_index_next = b_idx;
      record_length_next     = b_len;
      record_type_next       = b_type;
      page_fill_next         = b_fill;
      case (b_phase)
        ihp_pkg::PH_COLON: begin
          if (is_colon) begin
            parse_phase_next       = ihp_pkg::PH_RECORD;
            high_nibble_next       = 4'd0;
            nibble_pending_next    = 1'b0;
            record_byte_index_next = 9'd0;
            record_length_next     = 8'd0;
            record_type_next       = 8'd0;
          end else begin
            parse_phase_next = ihp_pkg::PH_HALT;
          end
        end
        ihp_pkg::PH_RECORD: begin
          if (is_newline) begin
            parse_phase_next    = ihp_pkg::PH_COLON;
            nibble_pending_next = 1'b0;
          end else if (hex.valid && !b_pending) begin
            high_nibble_next    = hex.value;
            nibble_pending_next = 1'b1;
          end else if (take_byte) begin
            nibble_pending_next = 1'b0;
            if (at_length) begin
              record_length_next = rec_byte;
            end else if (at_type) begin
              record_type_next = rec_byte;
              if (rec_unsup) begin
                parse_phase_next = ihp_pkg::PH_HALT;
              end else if (rec_eof) begin
                parse_phase_next = ihp_pkg::PH_HALT;
                page_fill_next   = '0;
              end
            end else if (data_hit) begin
              page_fill_next = fill_last ? '0 : b_fill + 1'b1;
            end
            if (!(at_type && (rec_unsup || rec_eof)) && b_idx != ihp_pkg::IDX_MAX) begin
              record_byte_index_next = b_idx + 9'd1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // result for this character
  always_comb begin
    emit        = 1'b0;
    emit_byte   = 8'd0;
    emit_repeat = 9'd0;
    emit_offset = 8'd0;
    emit_end    = 1'b0;
    emit_status = ihp_pkg::ST_RUN;
    case (b_phase)
      ihp_pkg::PH_COLON: begin
        if (!is_colon) begin
          emit        = 1'b1;
          emit_status = ihp_pkg::ST_BAD;
        end
      end
      ihp_pkg::PH_RECORD: begin
        if (take_byte) begin
          if (at_type) begin
            if (rec_unsup) begin
              emit        = 1'b1;
              emit_status = ihp_pkg::ST_UNSUP;
            end else if (rec_eof) begin
              emit        = 1'b1;
              emit_status = ihp_pkg::ST_OK;
              if (b_fill != '0) begin
                emit_byte   = ihp_pkg::PAD_BYTE;
                emit_repeat = 9'(pad_len);
                emit_offset = 8'(b_fill);
                emit_end    = 1'b1;
              end
            end
          end else if (!at_length && data_hit) begin
            emit        = 1'b1;
            emit_byte   = rec_byte;
            emit_repeat = 9'd1;
            emit_offset = 8'(b_fill);
            emit_end    = fill_last;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase       <= ihp_pkg::PH_COLON;
      high_nibble       <= 4'd0;
      nibble_pending    <= 1'b0;
      record_byte_index <= 9'd0;
      record_length     <= 8'd0;
      record_type       <= 8'd0;
      page_fill         <= '0;
      result_valid      <= 1'b0;
    end else begin
      parse_phase       <= parse_phase_next;
      high_nibble       <= high_nibble_next;
      nibble_pending    <= nibble_pending_next;
      record_byte_index <= record_byte_index_next;
      record_length     <= record_length_next;
      record_type       <= record_type_next;
      page_fill         <= page_fill_next;
      if (accept) begin
        result_valid <= emit;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      byte_value   <= emit_byte;
      repeat_count <= emit_repeat;
      page_offset  <= emit_offset;
      page_end     <= emit_end;
      parse_status <= emit_status;
    end
  end

  // page fill never reaches a full page
  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    page_fill < FILL_W'(PAGE_BYTES))
    else $error("page fill out of range");

  // a pending nibble only exists inside a record
  a_nibble_in_record: assert property (@(posedge clk) disable iff (rst)
    nibble_pending |-> parse_phase == ihp_pkg::PH_RECORD)
    else $error("nibble pending outside a record");

  // halted parser stays halted and silent until restart
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    (accept && !restart && parse_phase == ihp_pkg::PH_HALT) |=>
      (parse_phase == ihp_pkg::PH_HALT && !result_valid))
    else $error("halted parser moved on");

  // running items carry exactly one data byte
  a_run_single: assert property (@(posedge clk) disable iff (rst)
    (result_valid && parse_status == ihp_pkg::ST_RUN) |-> repeat_count == 9'd1)
    else $error("data item with bad repeat count");

  // a padding run only closes a page at end of file
  a_pad_end: assert property (@(posedge clk) disable iff (rst)
    (result_valid && byte_value == ihp_pkg::PAD_BYTE && parse_status == ihp_pkg::ST_OK &&
     repeat_count != 9'd0) |-> page_end)
    else $error("padding run without page end");

endmodule

`default_nettype wire
